@@ hw/rtl/tick_clock_with_slot_timer_chain_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the tick clock core
// Concurrent assertion wrappers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TICK_CLOCK_WITH_SLOT_TIMER_CHAIN_CORE_ASSERT_SVH
`define TICK_CLOCK_WITH_SLOT_TIMER_CHAIN_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define TCST_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: assertion failed");
// A condition that must be followed in the next clock cycle by a consequence.
`define TCST_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define TCST_ASSERT(lbl, clk, rstn, prop)
`define TCST_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ hw/rtl/tcst_pkg.sv @@
// ----------------------------------------------------------------------------
// Tick clock package
// Widths, constants, command codes and the structs shared between modules.
// ----------------------------------------------------------------------------
package tcst_pkg;

  // Chain storage depth and the widths that follow from it.
  localparam int MaxEntries = 64;
  localparam int EntryW     = $clog2(MaxEntries);
  localparam int CountW     = $clog2(MaxEntries + 1);

  // Field widths.
  localparam int CmdW     = 2;
  localparam int WaitW    = 16;
  localparam int SlotMsW  = 10;
  localparam int SlotUsW  = 20;
  localparam int RemW     = 36;
  localparam int MicroW   = 20;
  localparam int SecW     = 12;
  localparam int HourW    = 5;
  localparam int DayW     = 8;

  // Time constants.
  localparam int TickUs      = 50;
  localparam int UsPerSec    = 1000000;
  localparam int SecPerHour  = 3600;
  localparam int HoursPerDay = 24;
  localparam int UsPerMs     = 1000;

  // Command codes carried by an input transaction.
  typedef enum logic [CmdW-1:0] {
    CmdTick   = 2'd0,
    CmdLoad   = 2'd1,
    CmdCancel = 2'd2,
    CmdNop    = 2'd3
  } cmd_e;

  // One input item as held in the input register.
  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [EntryW-1:0] slot_index;
    logic [WaitW-1:0]  wait_slots;
    logic              load_last;
  } item_t;

  // Decoded request to the chain unit.
  typedef struct packed {
    logic              tick;
    logic              load;
    logic              cancel;
    logic [EntryW-1:0] slot_index;
    logic [WaitW-1:0]  wait_slots;
    logic              load_last;
  } chain_req_t;

  // Chain status after the current item.
  typedef struct packed {
    logic              running;
    logic [EntryW-1:0] entry;
    logic              expired;
  } chain_stat_t;

  // Wall clock after the current item.
  typedef struct packed {
    logic [MicroW-1:0] micros;
    logic [SecW-1:0]   seconds;
    logic [HourW-1:0]  hours;
    logic [DayW-1:0]   days;
    logic              led_level;
  } wall_time_t;

endpackage

@@ hw/rtl/tcst_if.sv @@
// ----------------------------------------------------------------------------
// Tick clock channel interfaces
// Valid/ready channels for items, results and the slot length register.
// ----------------------------------------------------------------------------
interface tcst_item_if;
  import tcst_pkg::*;

  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   cmd;
  logic [EntryW-1:0] slot_index;
  logic [WaitW-1:0]  wait_slots;
  logic              load_last;

  modport source (output valid, output cmd, output slot_index, output wait_slots,
                  output load_last, input ready);
  modport sink   (input valid, input cmd, input slot_index, input wait_slots,
                  input load_last, output ready);
endinterface

interface tcst_result_if;
  import tcst_pkg::*;

  logic              valid;
  logic              ready;
  logic [MicroW-1:0] micros;
  logic [SecW-1:0]   seconds;
  logic [HourW-1:0]  hours;
  logic [DayW-1:0]   days;
  logic              led_level;
  logic              chain_running;
  logic [EntryW-1:0] current_entry;
  logic              entry_expired;

  modport source (output valid, output micros, output seconds, output hours,
                  output days, output led_level, output chain_running,
                  output current_entry, output entry_expired, input ready);
  modport sink   (input valid, input micros, input seconds, input hours,
                  input days, input led_level, input chain_running,
                  input current_entry, input entry_expired, output ready);
endinterface

interface tcst_cfg_if;
  import tcst_pkg::*;

  logic               valid;
  logic               ready;
  logic [SlotMsW-1:0] slot_length_ms;

  modport source (output valid, output slot_length_ms, input ready);
  modport sink   (input valid, input slot_length_ms, output ready);
endinterface

@@ hw/rtl/tcst_clock.sv @@
// ----------------------------------------------------------------------------
// Tick clock wall time counters
// Microsecond, second, hour and day counters with the once-a-second LED.
// ----------------------------------------------------------------------------
`include "tick_clock_with_slot_timer_chain_core_assert.svh"

module tcst_clock (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tick_en_i,
  output tcst_pkg::wall_time_t time_o
);
  import tcst_pkg::*;

  logic [MicroW-1:0] micro_q, micro_d;
  logic [SecW-1:0]   sec_q, sec_d;
  logic [HourW-1:0]  hour_q, hour_d;
  logic [DayW-1:0]   day_q, day_d;
  logic              led_next_q, led_next_d;
  logic              led_out_q, led_out_d;

  logic [MicroW:0]   micro_sum;
  logic [SecW:0]     sec_sum;
  logic [HourW:0]    hour_sum;
  logic              sec_wrap;

  // Incremented values, one bit wider so that a value past its limit still carries.
  assign micro_sum = {1'b0, micro_q} + (MicroW + 1)'(TickUs);
  assign sec_sum   = {1'b0, sec_q} + (SecW + 1)'(1);
  assign hour_sum  = {1'b0, hour_q} + (HourW + 1)'(1);
  assign sec_wrap  = micro_sum >= (MicroW + 1)'(UsPerSec);

  // Carry chain: microseconds into seconds into hours into days.
  always_comb begin
    micro_d    = micro_q;
    sec_d      = sec_q;
    hour_d     = hour_q;
    day_d      = day_q;
    led_next_d = led_next_q;
    led_out_d  = led_out_q;
    if (tick_en_i) begin
      if (sec_wrap) begin
        micro_d = '0;
        if (sec_sum >= (SecW + 1)'(SecPerHour)) begin
          sec_d = '0;
          if (hour_sum >= (HourW + 1)'(HoursPerDay)) begin
            hour_d = '0;
            day_d  = day_q + DayW'(1);
          end else begin
            hour_d = hour_sum[HourW-1:0];
          end
        end else begin
          sec_d = sec_sum[SecW-1:0];
        end
        // Drive the stored level on the second boundary, then flip it.
        led_out_d  = led_next_q;
        led_next_d = ~led_next_q;
      end else begin
        micro_d = micro_sum[MicroW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      micro_q    <= '0;
      sec_q      <= '0;
      hour_q     <= '0;
      day_q      <= '0;
      led_next_q <= 1'b1;
      led_out_q  <= 1'b0;
    end else begin
      micro_q    <= micro_d;
      sec_q      <= sec_d;
      hour_q     <= hour_d;
      day_q      <= day_d;
      led_next_q <= led_next_d;
      led_out_q  <= led_out_d;
    end
  end

  // The result reports the time after this item has been applied.
  assign time_o.micros    = micro_d;
  assign time_o.seconds   = sec_d;
  assign time_o.hours     = hour_d;
  assign time_o.days      = day_d;
  assign time_o.led_level = led_out_d;

  // Assertions.
  `TCST_ASSERT(a_micro_range, clk_i, rst_ni, micro_q < MicroW'(UsPerSec))
  `TCST_ASSERT(a_led_differs, clk_i, rst_ni, led_out_q != led_next_q)
  `TCST_ASSERT_NEXT(a_led_toggles, clk_i, rst_ni, tick_en_i && sec_wrap, led_out_q != $past(led_out_q))

endmodule

@@ hw/rtl/tcst_chain.sv @@
// ----------------------------------------------------------------------------
// Tick clock wait chain
// Entry memory with a bypassed read port and the chain countdown control.
// ----------------------------------------------------------------------------
`include "tick_clock_with_slot_timer_chain_core_assert.svh"

module tcst_chain (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tcst_pkg::chain_req_t                req_i,
  input  logic [tcst_pkg::SlotUsW-1:0]        slot_us_i,
  output tcst_pkg::chain_stat_t               stat_o
);
  import tcst_pkg::*;

  // Entry store: one write and one registered read per cycle.
  logic [RemW-1:0]   mem_q [MaxEntries];
  logic [RemW-1:0]   rd_data_q;
  logic [RemW-1:0]   byp_data_q;
  logic              byp_q;

  logic [CountW-1:0] active_q, active_d;
  logic [EntryW-1:0] ptr_q, ptr_d;

  logic              wr_en;
  logic [EntryW-1:0] wr_addr;
  logic [RemW-1:0]   wr_data;
  logic [RemW-1:0]   cur;
  logic [RemW-1:0]   load_us;
  logic              expired;

  // Remaining time of the entry under the pointer, with the last write forwarded.
  assign cur = byp_q ? byp_data_q : rd_data_q;

  // Loaded wait converted to microseconds.
  assign load_us = RemW'(req_i.wait_slots) * RemW'(slot_us_i);

  // Countdown, load and cancel handling.
  always_comb begin
    active_d = active_q;
    ptr_d    = ptr_q;
    wr_en    = 1'b0;
    wr_addr  = ptr_q;
    wr_data  = '0;
    expired  = 1'b0;
    if (req_i.tick) begin
      if (active_q != '0) begin
        wr_en = 1'b1;
        if (cur <= RemW'(TickUs)) begin
          expired = 1'b1;
          if ({1'b0, ptr_q} + CountW'(1) >= active_q) begin
            active_d = '0;
          end else begin
            ptr_d = ptr_q + EntryW'(1);
          end
        end else begin
          wr_data = cur - RemW'(TickUs);
        end
      end
    end else if (req_i.load) begin
      if ({1'b0, req_i.slot_index} < CountW'(MaxEntries)) begin
        if (req_i.slot_index == '0) begin
          active_d = '0;
        end
        wr_en   = 1'b1;
        wr_addr = req_i.slot_index;
        wr_data = load_us;
        if (req_i.load_last) begin
          active_d = {1'b0, req_i.slot_index} + CountW'(1);
          ptr_d    = '0;
        end
      end
    end else if (req_i.cancel) begin
      active_d = '0;
    end
  end

  // Memory array, read at the pointer of the next cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q  <= mem_q[ptr_d];
    byp_data_q <= wr_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q    <= 1'b0;
      active_q <= '0;
      ptr_q    <= '0;
    end else begin
      byp_q    <= wr_en && (wr_addr == ptr_d);
      active_q <= active_d;
      ptr_q    <= ptr_d;
    end
  end

  assign stat_o.running = active_d != '0;
  assign stat_o.entry   = ptr_d;
  assign stat_o.expired = expired;

  // Assertions.
  `TCST_ASSERT(a_active_range, clk_i, rst_ni, active_q <= CountW'(MaxEntries))
  `TCST_ASSERT_NEXT(a_ptr_step, clk_i, rst_ni, req_i.tick, (ptr_q == $past(ptr_q)) || (ptr_q == $past(ptr_q) + EntryW'(1)))
  `TCST_ASSERT_NEXT(a_expire_moves, clk_i, rst_ni, expired && (active_d != '0), ptr_q != $past(ptr_q))

endmodule

@@ hw/rtl/tick_clock_with_slot_timer_chain_core.sv @@
// ----------------------------------------------------------------------------
// Tick clock with slot timer chain
// Wall clock driven by 50 us ticks, with a chain of expiring wait entries.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless the result side stalls, and
// returns one result per item: an input register feeds the clock counters and
// the chain unit, whose answer is caught in a result register. The chain
// entries sit in a 64-entry memory with one write and one read port; the read
// is issued for the pointer of the following cycle and the write of the same
// cycle is forwarded, so a tick can follow any item at once. The memory has
// no clearing pass and is usable straight after reset; an entry reads as
// undefined until it has been loaded. The slot length register may be written
// only while no transaction is in flight.
`include "tick_clock_with_slot_timer_chain_core_assert.svh"

module tick_clock_with_slot_timer_chain_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcst_cfg_if.sink    cfg_i,
  tcst_item_if.sink   item_i,
  tcst_result_if.source result_o
);
  import tcst_pkg::*;

  logic               in_valid_q;
  item_t              in_q;
  logic               out_valid_q;
  wall_time_t         time_q;
  chain_stat_t        stat_q;
  logic [SlotUsW-1:0] slot_us_q, slot_us_d;

  logic               accept;
  logic               exec_go;
  logic               tick_en;
  chain_req_t         req;
  wall_time_t         time_nxt;
  chain_stat_t        stat_nxt;

  // Slot length register, kept as microseconds per slot.
  assign cfg_i.ready = 1'b1;
  assign slot_us_d   = SlotUsW'(SlotUsW'(cfg_i.slot_length_ms) * SlotUsW'(UsPerMs));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_us_q <= SlotUsW'(UsPerMs);
    end else if (cfg_i.valid) begin
      slot_us_q <= slot_us_d;
    end
  end

  // Handshake: the item moves on when the result register is free or drains.
  assign exec_go      = in_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !in_valid_q || exec_go;
  assign accept       = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (exec_go) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q.cmd        <= item_i.cmd;
      in_q.slot_index <= item_i.slot_index;
      in_q.wait_slots <= item_i.wait_slots;
      in_q.load_last  <= item_i.load_last;
    end
  end

  // Command decode for the clock and the chain.
  always_comb begin
    req.tick       = 1'b0;
    req.load       = 1'b0;
    req.cancel     = 1'b0;
    req.slot_index = in_q.slot_index;
    req.wait_slots = in_q.wait_slots;
    req.load_last  = in_q.load_last;
    if (exec_go) begin
      case (cmd_e'(in_q.cmd))
        CmdTick:   req.tick   = 1'b1;
        CmdLoad:   req.load   = 1'b1;
        CmdCancel: req.cancel = 1'b1;
        default:   ;
      endcase
    end
  end

  assign tick_en = req.tick;

  tcst_clock u_clock (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_en_i (tick_en),
    .time_o    (time_nxt)
  );

  tcst_chain u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .slot_us_i (slot_us_q),
    .stat_o    (stat_nxt)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_go) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      time_q <= time_nxt;
      stat_q <= stat_nxt;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.micros        = time_q.micros;
  assign result_o.seconds       = time_q.seconds;
  assign result_o.hours         = time_q.hours;
  assign result_o.days          = time_q.days;
  assign result_o.led_level     = time_q.led_level;
  assign result_o.chain_running = stat_q.running;
  assign result_o.current_entry = stat_q.entry;
  assign result_o.entry_expired = stat_q.expired;

  // Assertions.
  `TCST_ASSERT(a_stall_cause, clk_i, rst_ni, item_i.ready || (in_valid_q && out_valid_q && !result_o.ready))
  `TCST_ASSERT_NEXT(a_exec_result, clk_i, rst_ni, exec_go, out_valid_q)
  `TCST_ASSERT_NEXT(a_result_hold, clk_i, rst_ni, out_valid_q && !result_o.ready, out_valid_q)

endmodule
